// File: design/pal_pkg.sv
// Shared types and constants for the positional array list.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

   localparam int CAPACITY_DEF = 128;
   localparam int KIND_W       = 2;
   localparam int POS_W        = 7;
   localparam int VAL_W        = 32;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ   = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_APPEND = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // operation broadcast to every cell in the chain
   typedef struct packed {
      logic ins;
      logic del;
   } cell_op_type;

endpackage

`default_nettype wire

// File: design/pal_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on pal_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pal_req_if
   import pal_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [POS_W-1:0]   position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface pal_rsp_if
   import pal_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] read_value;
   logic [STATUS_W-1:0]     status;
   logic [COUNT_OUT_W-1:0]  entry_count;
   logic                    list_empty;
   logic                    list_full;

   modport source (output valid, output read_value, output status, output entry_count,
                   output list_empty, output list_full, input ready);
   modport sink   (input valid, input read_value, input status, input entry_count,
                   input list_empty, input list_full, output ready);
endinterface

`default_nettype wire

// File: design/pal_cell.sv
// One storage cell of the list chain: holds a single entry and shifts
// toward either neighbor. Depends on pal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell
   import pal_pkg::*;
#(
   parameter int CNT_W = 8,
   parameter int INDEX = 0
) (
   input  wire logic                    clock,
   input  wire cell_op_type             op,
   input  wire logic [CNT_W-1:0]        target,
   input  wire logic [VAL_W-1:0]        value,
   input  wire logic [VAL_W-1:0]        lower_data,
   input  wire logic [VAL_W-1:0]        upper_data,
   output logic      [VAL_W-1:0]        data,
   output logic      [VAL_W-1:0]        sel_data
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;
   logic             hit;
   logic             above;

   assign hit   = (target == MY_INDEX);
   assign above = (MY_INDEX > target);

   always_comb begin
      data_in = data_ff;
      if (op.ins) begin
         // open a gap at the target, push later entries up
         if (hit) begin
            data_in = value;
         end else if (above) begin
            data_in = lower_data;
         end
      end else if (op.del) begin
         // close the gap, pull later entries down
         if (hit || above) begin
            data_in = upper_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign sel_data = data_ff & {VAL_W{hit}};

endmodule

`default_nettype wire

// File: design/positional_array_list_unit.sv
// Positional array list: an ordered list of up to CAPACITY signed 32-bit
// entries held in a chain of cells that all shift at once. For a read,
// insert, append or delete, a request is accepted whenever the response
// register is empty or being drained, and its response word appears the
// following cycle, so one request per clock is sustained while responses
// are taken. Errors (position out of range, list full) leave the list
// untouched. Depends on pal_pkg, pal_if and pal_cell.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit
   import pal_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pal_req_if.sink    req_chan,
   pal_rsp_if.source  rsp_chan
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int OUT_XW = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] read_value_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [COUNT_OUT_W-1:0] entry_count_ff;
   logic             list_empty_ff;
   logic             list_full_ff;

   logic             accept;
   logic             is_full;
   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   cell_op_type      op;
   logic [CNT_W-1:0] target;
   status_type       status;
   logic [VAL_W-1:0] rv;
   logic [VAL_W-1:0] sel_value;
   logic [OUT_XW-1:0] count_out;

   logic [VAL_W-1:0] cell_data [CAPACITY];
   logic [VAL_W-1:0] cell_sel  [CAPACITY];

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign is_full        = (count_ff == FULL_COUNT);
   assign pos_cmp        = CMP_W'(req_chan.position);
   assign cnt_cmp        = CMP_W'(count_ff);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] lower;
      logic [VAL_W-1:0] upper;
      if (i == 0) begin : g_first
         assign lower = req_chan.value;
      end else begin : g_mid_lo
         assign lower = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper = cell_data[i];
      end else begin : g_mid_hi
         assign upper = cell_data[i+1];
      end
      pal_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .target     (target),
         .value      (req_chan.value),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[i]),
         .sel_data   (cell_sel[i])
      );
   end

   // only the addressed cell drives nonzero, so OR the row together
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_value = sel_value | cell_sel[i];
      end
   end

   always_comb begin
      op       = '0;
      target   = pos_cmp[CNT_W-1:0];
      count_in = count_ff;
      status   = ST_OK;
      rv       = '0;
      case (kind_type'(req_chan.kind))
         KIND_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               rv = sel_value;
            end
         end
         KIND_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else if (pos_cmp > cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               op.ins   = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_APPEND: begin
            target = count_ff;
            if (is_full) begin
               status = ST_FULL;
            end else begin
               op.ins   = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_DELETE: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               rv       = sel_value;
               op.del   = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign count_out = OUT_XW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the response word until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff  <= rv;
         status_ff      <= status;
         entry_count_ff <= count_out[COUNT_OUT_W-1:0];
         list_empty_ff  <= (count_in == '0);
         list_full_ff   <= (count_in == FULL_COUNT);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = read_value_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_count = entry_count_ff;
   assign rsp_chan.list_empty  = list_empty_ff;
   assign rsp_chan.list_full   = list_full_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_FULL |-> list_full_ff)
      else $error("full status on a list that is not full");

   a_error_no_change : assert property (@(posedge clock) disable iff (reset)
      accept && status != ST_OK |=> $stable(count_ff))
      else $error("failed request changed the list");

endmodule

`default_nettype wire
